FILE: rtl/slc_pkg.sv
// package for the single button lamp controller
// holds payload structs, register index codes and reset values; no dependencies
package slc_pkg;

    localparam int LEVEL_STEPS_DEF = 10;
    localparam int COUNT_BITS_DEF  = 16;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int TICK_BITS     = 16;
    localparam int CODE_BITS     = 8;
    localparam int LEVEL_BITS    = 4;

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_LONG_PRESS  = 3'd0;
    localparam t_cfg_idx CFG_SHORT_PRESS = 3'd1;
    localparam t_cfg_idx CFG_IDLE_LIMIT  = 3'd2;
    localparam t_cfg_idx CFG_FULL_CODE   = 3'd3;
    localparam t_cfg_idx CFG_START_DUTY  = 3'd4;
    localparam t_cfg_idx CFG_DUTY_STEP   = 3'd5;

    localparam logic [TICK_BITS-1:0] RST_LONG_PRESS  = 16'd14500;
    localparam logic [TICK_BITS-1:0] RST_SHORT_PRESS = 16'd600;
    localparam logic [TICK_BITS-1:0] RST_IDLE_LIMIT  = 16'd65000;
    localparam logic [CODE_BITS-1:0] RST_FULL_CODE   = 8'd129;
    localparam logic [CODE_BITS-1:0] RST_START_DUTY  = 8'd20;
    localparam logic [CODE_BITS-1:0] RST_DUTY_STEP   = 8'd40;

    typedef struct packed {
        logic                 button_down;
        logic [CODE_BITS-1:0] battery_sample;
    } t_lamp_in;

    typedef struct packed {
        logic [CODE_BITS-1:0]  lamp_duty;
        logic                  lamp_on;
        logic                  sleep_request;
        logic                  level_valid;
        logic [LEVEL_BITS-1:0] battery_level;
    } t_lamp_out;

endpackage

FILE: rtl/single_button_lamp_controller_top.sv
// single button lamp controller: press timing, duty control and battery level report
// depends on slc_pkg
//
// usage:
//   input channel (i_in_valid / o_in_stall / i_in_data) takes one tick item per
//   transfer: button level and battery sample. each tick gives exactly one result on
//   the output channel (o_out_valid / i_out_stall / o_out_data).
//   the result of a tick is registered in the output register, or in the skid entry while the output is stalled.
//   throughput is one tick per cycle while the input is not stalled, set by the single state update per tick.
//   the output register is backed by one skid entry, so a tick is still taken while a
//   result waits; the input stalls only once both hold results.
//   configuration writes use i_cfg_valid / o_cfg_ready, always ready; index 0..5
//   selects the register, other indexes are dropped. write only while idle.
//   synchronous active-low reset clears lamp state, counters and both result slots
//   and loads the register defaults.
module single_button_lamp_controller_top
    import slc_pkg::*;
#(
    parameter int LEVEL_STEPS = LEVEL_STEPS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_lamp_in                 i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_lamp_out                o_out_data,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int CMP_BITS = (COUNT_BITS > TICK_BITS) ? COUNT_BITS : TICK_BITS;
    localparam logic [LEVEL_BITS-1:0] LEVEL_FULL = LEVEL_BITS'(LEVEL_STEPS);

    // configuration registers
    logic [TICK_BITS-1:0] r_long_press;
    logic [TICK_BITS-1:0] r_short_press;
    logic [TICK_BITS-1:0] r_idle_limit;
    logic [CODE_BITS-1:0] r_full_code;
    logic [CODE_BITS-1:0] r_start_duty;
    logic [CODE_BITS-1:0] r_duty_step;

    // lamp state
    logic                  r_lamp_mode,   n_lamp_mode;
    logic [COUNT_BITS-1:0] r_press_count, n_press_count;
    logic                  r_was_pressed, n_was_pressed;
    logic                  r_long_fired,  n_long_fired;
    logic [COUNT_BITS-1:0] r_idle_count,  n_idle_count;
    logic [CODE_BITS-1:0]  r_duty,        n_duty;

    // result slots
    logic      r_out_valid, r_skid_valid;
    t_lamp_out r_out, r_skid;
    t_lamp_out n_result;

    logic                  in_acc;
    logic                  out_free;
    logic                  sleep_now;
    logic                  level_now;
    logic [LEVEL_BITS-1:0] level_val;
    logic [CODE_BITS-1:0]  gap;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_acc   = i_in_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press  <= RST_LONG_PRESS;
            r_short_press <= RST_SHORT_PRESS;
            r_idle_limit  <= RST_IDLE_LIMIT;
            r_full_code   <= RST_FULL_CODE;
            r_start_duty  <= RST_START_DUTY;
            r_duty_step   <= RST_DUTY_STEP;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LONG_PRESS:  r_long_press  <= i_cfg_data;
                CFG_SHORT_PRESS: r_short_press <= i_cfg_data;
                CFG_IDLE_LIMIT:  r_idle_limit  <= i_cfg_data;
                CFG_FULL_CODE:   r_full_code   <= i_cfg_data[CODE_BITS-1:0];
                CFG_START_DUTY:  r_start_duty  <= i_cfg_data[CODE_BITS-1:0];
                CFG_DUTY_STEP:   r_duty_step   <= i_cfg_data[CODE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // charge level: steps minus shortfall below full, floored at zero
    assign gap = r_full_code - i_in_data.battery_sample;
    always_comb begin
        if (i_in_data.battery_sample >= r_full_code) begin
            level_val = LEVEL_FULL;
        end else if (gap >= CODE_BITS'(LEVEL_STEPS)) begin
            level_val = '0;
        end else begin
            level_val = LEVEL_FULL - gap[LEVEL_BITS-1:0];
        end
    end

    always_comb begin
        n_lamp_mode   = r_lamp_mode;
        n_press_count = r_press_count;
        n_was_pressed = r_was_pressed;
        n_long_fired  = r_long_fired;
        n_idle_count  = r_idle_count;
        n_duty        = r_duty;
        sleep_now     = 1'b0;
        level_now     = 1'b0;
        if (i_in_data.button_down) begin
            if (!r_was_pressed) begin
                n_was_pressed = 1'b1;
                n_press_count = '0;
                n_long_fired  = 1'b0;
            end
            if (!n_long_fired) begin
                n_press_count = n_press_count + COUNT_BITS'(1);
                if (CMP_BITS'(n_press_count) > CMP_BITS'(r_long_press)) begin
                    n_long_fired = 1'b1;
                    if (r_lamp_mode) begin
                        level_now = 1'b1;
                        sleep_now = 1'b1;
                    end else begin
                        n_duty      = r_start_duty;
                        n_lamp_mode = 1'b1;
                    end
                end
            end
        end else begin
            if (r_was_pressed && r_lamp_mode) begin
                if (r_long_fired) begin
                    n_press_count = '0;
                end
                if (CMP_BITS'(n_press_count) > CMP_BITS'(r_short_press)) begin
                    n_duty = r_duty + r_duty_step;
                end
            end
            n_was_pressed = 1'b0;
            n_idle_count  = r_idle_count + COUNT_BITS'(1);
            if (CMP_BITS'(n_idle_count) > CMP_BITS'(r_idle_limit) && !r_lamp_mode) begin
                sleep_now = 1'b1;
            end
        end
        // power down returns everything to reset
        if (sleep_now) begin
            n_lamp_mode   = 1'b0;
            n_press_count = '0;
            n_was_pressed = 1'b0;
            n_long_fired  = 1'b0;
            n_idle_count  = '0;
            n_duty        = '0;
        end
    end

    always_comb begin
        n_result.lamp_duty     = n_duty;
        n_result.lamp_on       = n_lamp_mode;
        n_result.sleep_request = sleep_now;
        n_result.level_valid   = level_now;
        n_result.battery_level = level_now ? level_val : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lamp_mode   <= 1'b0;
            r_press_count <= '0;
            r_was_pressed <= 1'b0;
            r_long_fired  <= 1'b0;
            r_idle_count  <= '0;
            r_duty        <= '0;
        end else if (in_acc) begin
            r_lamp_mode   <= n_lamp_mode;
            r_press_count <= n_press_count;
            r_was_pressed <= n_was_pressed;
            r_long_fired  <= n_long_fired;
            r_idle_count  <= n_idle_count;
            r_duty        <= n_duty;
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_acc;
            end
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_acc) begin
                r_out <= n_result;
            end
        end else if (in_acc) begin
            r_skid <= n_result;
        end
    end

endmodule

FILE: rtl/slc_checker.sv
// port-level checks for the single button lamp controller
// depends on slc_pkg; bound to single_button_lamp_controller_top
module slc_checker
    import slc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_lamp_out o_out_data
);

    // a level report only comes with the power-down tick
    a_level_sleeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.level_valid |-> o_out_data.sleep_request)
        else $error("level report without sleep request");

    // power down shows the reset state
    a_sleep_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.sleep_request
            |-> !o_out_data.lamp_on && o_out_data.lamp_duty == '0)
        else $error("sleep result not in reset state");

    // input stalls only while a result is held at the output
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

endmodule

bind single_button_lamp_controller_top slc_checker u_slc_checker (.*);

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// self-checking bench for single_button_lamp_controller_top: a directed table, then random
// press/release sequences under several register settings
// depends on slc_pkg and the controller rtl
module tb_top;
    import slc_pkg::*;

    localparam int LEVELS = LEVEL_STEPS_DEF;
    localparam t_cfg_idx CFG_SPARE_LO = 3'd6;
    localparam t_cfg_idx CFG_SPARE_HI = 3'd7;

    typedef enum logic {ROW_TICK, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic               btn;
        logic [7:0]         sample;
        logic               typed;
        t_lamp_out          want;
        t_cfg_idx           idx;
        logic [15:0]        data;
    } t_row;

    logic                     i_clk;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    t_lamp_in                 i_in_data = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    t_lamp_out                o_out_data;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    // typed expectation travels with the tick it belongs to
    logic      row_typed = 1'b0;
    t_lamp_out row_want = '0;

    bit        idle_on = 1'b1;
    int        bad_results = 0;
    t_lamp_out pending_out[$];
    t_row      plan[$];

    // register mirror
    logic [15:0] long_r, short_r, idle_r;
    logic [7:0]  full_r, start_r, step_r;
    // lamp state mirror
    logic        lamp_on_m, held_m, fired_m;
    logic [15:0] press_m, idle_m;
    logic [7:0]  duty_m;

    single_button_lamp_controller_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic void clear_lamp();
        lamp_on_m = 1'b0;
        press_m   = '0;
        held_m    = 1'b0;
        fired_m   = 1'b0;
        idle_m    = '0;
        duty_m    = '0;
    endfunction

    function automatic t_lamp_out step_lamp(input t_lamp_in t);
        t_lamp_out  r;
        logic       sleep_now;
        logic       report;
        logic [3:0] lvl;
        logic [7:0] gap;
        sleep_now = 1'b0;
        report    = 1'b0;
        lvl       = '0;
        if (t.button_down) begin
            if (!held_m) begin
                held_m  = 1'b1;
                press_m = '0;
                fired_m = 1'b0;
            end
            if (!fired_m) press_m = press_m + 16'd1;
            if (!fired_m && press_m > long_r) begin
                fired_m = 1'b1;
                if (lamp_on_m) begin
                    gap = full_r - t.battery_sample;
                    if (t.battery_sample >= full_r) lvl = 4'(LEVELS);
                    else if (gap >= LEVELS) lvl = '0;
                    else lvl = 4'(LEVELS - gap);
                    report    = 1'b1;
                    sleep_now = 1'b1;
                    clear_lamp();
                end else begin
                    duty_m    = start_r;
                    lamp_on_m = 1'b1;
                end
            end
        end else begin
            if (held_m && lamp_on_m) begin
                // a long press never counts as a short one on release
                if (fired_m) press_m = '0;
                if (press_m > short_r) duty_m = duty_m + step_r;
            end
            held_m = 1'b0;
            idle_m = idle_m + 16'd1;
            if (idle_m > idle_r && !lamp_on_m) begin
                sleep_now = 1'b1;
                clear_lamp();
            end
        end
        r.lamp_duty     = duty_m;
        r.lamp_on       = lamp_on_m;
        r.sleep_request = sleep_now;
        r.level_valid   = report;
        r.battery_level = lvl;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            bad_results++;
        end
    endtask

    always @(posedge i_clk) begin : score
        t_lamp_out want;
        t_lamp_out calc;
        if (o_out_valid && !i_out_stall) begin
            if (pending_out.size() == 0) begin
                $error("result transfer with nothing pending: %h", o_out_data);
                bad_results++;
            end else begin
                want = pending_out.pop_front();
                check_field("lamp_duty", want.lamp_duty, o_out_data.lamp_duty);
                check_field("lamp_on", want.lamp_on, o_out_data.lamp_on);
                check_field("sleep_request", want.sleep_request, o_out_data.sleep_request);
                check_field("level_valid", want.level_valid, o_out_data.level_valid);
                check_field("battery_level", want.battery_level, o_out_data.battery_level);
            end
        end
        if (i_in_valid && !o_in_stall) begin
            calc = step_lamp(i_in_data);
            pending_out.push_back(row_typed ? row_want : calc);
        end
    end

    // receiver back-pressure in bursts
    initial begin
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_tick(input logic b, input logic [7:0] s,
                             input logic typed = 1'b0, input t_lamp_out want = '0);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= t_lamp_in'{b, s};
        row_typed  <= typed;
        row_want   <= want;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_sample();
        int v;
        if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
        // bias toward the region around full charge, mostly just below it
        v = int'(full_r) + int'($urandom_range(0, 14)) - 12;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    task automatic hold_button(input logic b, input int n);
        repeat (n) send_tick(b, pick_sample());
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_out.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_LONG_PRESS:  long_r  = data;
            CFG_SHORT_PRESS: short_r = data;
            CFG_IDLE_LIMIT:  idle_r  = data;
            CFG_FULL_CODE:   full_r  = data[7:0];
            CFG_START_DUTY:  start_r = data[7:0];
            CFG_DUTY_STEP:   step_r  = data[7:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic [15:0] l, input logic [15:0] s,
                                  input logic [15:0] i, input logic [15:0] f,
                                  input logic [15:0] st, input logic [15:0] d);
        write_reg(CFG_LONG_PRESS, l);
        write_reg(CFG_SHORT_PRESS, s);
        write_reg(CFG_IDLE_LIMIT, i);
        write_reg(CFG_FULL_CODE, f);
        write_reg(CFG_START_DUTY, st);
        write_reg(CFG_DUTY_STEP, d);
        i_cfg_valid <= 1'b0;
    endtask

    // press/release sequences sized around the thresholds, with some lone toggles
    task automatic run_phase(input int n_items);
        int sent, hold, rel, lp, sp, ip;
        sent = 0;
        lp = (long_r > 60) ? 60 : int'(long_r);
        sp = (short_r > 60) ? 60 : int'(short_r);
        ip = (idle_r > 60) ? 60 : int'(idle_r);
        while (sent < n_items) begin
            if ($urandom_range(0, 7) == 0) begin
                send_tick(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                sent++;
            end else begin
                case ($urandom_range(0, 3))
                    0: hold = $urandom_range(1, sp + 1);
                    1: hold = $urandom_range(sp + 1, lp + 1);
                    2: hold = lp + $urandom_range(1, 3);
                    default: hold = $urandom_range(1, 6);
                endcase
                case ($urandom_range(0, 2))
                    0: rel = $urandom_range(1, 3);
                    1: rel = $urandom_range(1, ip + 2);
                    default: rel = ip + 1;
                endcase
                hold_button(1'b1, hold);
                hold_button(1'b0, rel);
                sent += hold + rel;
            end
        end
    endtask

    function automatic void add_tick(input logic b, input logic [7:0] s,
                                     input logic typed = 1'b0, input t_lamp_out want = '0);
        plan.push_back(t_row'{ROW_TICK, b, s, typed, want, '0, '0});
    endfunction

    function automatic void add_reg(input t_cfg_idx idx, input logic [15:0] data);
        plan.push_back(t_row'{ROW_REG, 1'b0, 8'd0, 1'b0, t_lamp_out'('0), idx, data});
    endfunction

    initial begin
        int l, n;
        long_r  = RST_LONG_PRESS;
        short_r = RST_SHORT_PRESS;
        idle_r  = RST_IDLE_LIMIT;
        full_r  = RST_FULL_CODE;
        start_r = RST_START_DUTY;
        step_r  = RST_DUTY_STEP;
        clear_lamp();

        // defaults after reset: nothing can happen in a few ticks
        add_tick(1'b0, 8'h00, 1'b1, '0);
        add_tick(1'b1, 8'hFF, 1'b1, '0);
        add_tick(1'b0, 8'h80, 1'b1, '0);
        // short thresholds; upper data bits of byte registers are dropped
        add_reg(CFG_LONG_PRESS, 16'd2);
        add_reg(CFG_SHORT_PRESS, 16'd1);
        add_reg(CFG_IDLE_LIMIT, 16'd3);
        add_reg(CFG_FULL_CODE, 16'hFF64);
        add_reg(CFG_START_DUTY, 16'h12FF);
        add_reg(CFG_DUTY_STEP, 16'hAB01);
        add_reg(CFG_SPARE_LO, 16'h0000);
        add_reg(CFG_SPARE_HI, 16'hFFFF);
        // long press from off turns on at full start duty
        add_tick(1'b1, 8'h00);
        add_tick(1'b1, 8'h01);
        add_tick(1'b1, 8'h02, 1'b1, t_lamp_out'{8'd255, 1'b1, 1'b0, 1'b0, 4'd0});
        add_tick(1'b1, 8'h03);
        add_tick(1'b0, 8'h04);
        // short press wraps the duty
        add_tick(1'b1, 8'h05);
        add_tick(1'b1, 8'h06);
        add_tick(1'b0, 8'h07);
        // long press while on: level report at full charge, together with sleep
        add_tick(1'b1, 8'h10);
        add_tick(1'b1, 8'h20);
        add_tick(1'b1, 8'd100, 1'b1, t_lamp_out'{8'd0, 1'b0, 1'b1, 1'b1, 4'd10});
        // idle sleep while off
        add_tick(1'b0, 8'hAA);
        add_tick(1'b0, 8'h55);
        add_tick(1'b0, 8'hF0);
        add_tick(1'b0, 8'h0F, 1'b1, t_lamp_out'{8'd0, 1'b0, 1'b1, 1'b0, 4'd0});
        // back on, then a report just above the floor
        add_tick(1'b1, 8'h00);
        add_tick(1'b1, 8'h00);
        add_tick(1'b1, 8'h00);
        add_tick(1'b0, 8'h00);
        add_tick(1'b1, 8'h00);
        add_tick(1'b1, 8'h00);
        add_tick(1'b1, 8'd91);

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_REG) begin
                if (!i_cfg_valid) drain();
                write_reg(plan[k].idx, plan[k].data);
            end else begin
                i_cfg_valid <= 1'b0;
                send_tick(plan[k].btn, plan[k].sample, plan[k].typed, plan[k].want);
            end
        end
        drain();

        // the last phase runs with no idling on either side
        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
                1: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: apply_settings(16'd10, 16'd0, 16'hFFFF, 16'h00FF, 16'h00FF, 16'h00FF);
                3: apply_settings(16'd3, 16'hFFFF, 16'd0, 16'h0000, 16'h0080, 16'h0001);
                default: begin
                    l = $urandom_range(0, 30);
                    apply_settings(16'(l), 16'($urandom_range(0, l + 4)),
                                   16'($urandom_range(0, 50)), 16'($urandom_range(0, 65535)),
                                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
                end
            endcase
            idle_on = (ph != 11);
            run_phase(110);
            drain();
        end

        i_in_valid <= 1'b0;
        n = 0;
        while (pending_out.size() != 0 && n < 2000) begin
            @(negedge i_clk);
            n++;
        end
        repeat (4) @(negedge i_clk);
        if (pending_out.size() != 0) begin
            $error("%0d results never arrived", pending_out.size());
            bad_results++;
        end
        if (bad_results == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
